// File: sv/tup_pkg.sv
// ----------------------------------------------------------------------------
// tup_pkg: shared types and constants for the text to unsigned parser
// Character codes, item layouts, result status codes and the digit decoder.
// ----------------------------------------------------------------------------
package tup_pkg;

	// default sizing
	localparam int DEF_WIDTH     = 32;
	localparam int DEF_MAX_CHARS = 65536;

	// fixed field widths
	localparam int CHAR_W   = 8;
	localparam int RADIX_W  = 6;
	localparam int VALUE_W  = 32;
	localparam int OFFSET_W = 16;

	// digit value that marks a byte that is not a digit
	localparam logic [RADIX_W-1:0] NO_DIGIT = RADIX_W'(36);

	// bases used by prefix detection and the valid radix range
	localparam logic [RADIX_W-1:0] BASE_OCT = RADIX_W'(8);
	localparam logic [RADIX_W-1:0] BASE_DEC = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] BASE_HEX = RADIX_W'(16);
	localparam logic [RADIX_W-1:0] BASE_MIN = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] BASE_MAX = RADIX_W'(36);

	// character codes
	localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7a;
	localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5a;
	localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
	localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_DIGITS = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_t;

	typedef logic [RADIX_W-1:0] radix_t;

	// one input byte
	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} char_item_t;

	// one conversion result
	typedef struct packed {
		logic [VALUE_W-1:0]  value;
		logic [OFFSET_W-1:0] end_offset;
		status_t             status;
	} result_item_t;

	// digit value of a byte, NO_DIGIT when it is not 0-9, a-z or A-Z
	function automatic logic [RADIX_W-1:0] char_digit(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] d;
		begin
			d = CHAR_W'(NO_DIGIT);
			if (c >= CH_0 && c <= CH_9)
				d = c - CH_0;
			else if (c >= CH_LO_A && c <= CH_LO_Z)
				d = c - CH_LO_A + 8'd10;
			else if (c >= CH_UP_A && c <= CH_UP_Z)
				d = c - CH_UP_A + 8'd10;
			return d[RADIX_W-1:0];
		end
	endfunction

endpackage

// File: sv/tup_chan_if.sv
// ----------------------------------------------------------------------------
// tup_chan_if: valid/ready channel
// Carries one payload per transfer; the payload type is set per instance.
// ----------------------------------------------------------------------------
interface tup_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: sv/text_to_unsigned_parser.sv
// ----------------------------------------------------------------------------
// text_to_unsigned_parser: streaming string to unsigned integer converter
// Takes one byte per transfer, skips whitespace, takes a sign and a base
// prefix, accumulates digits and reports value, end offset and status on
// the byte marked last.
//
//  channel  dir  payload                            transfer when
//  chars    in   tup_pkg::char_item_t               chars.valid & chars.ready
//  result   out  tup_pkg::result_item_t             result.valid & result.ready
//  cfg      in   tup_pkg::radix_t (radix register)  cfg.valid & cfg.ready
//
// One byte per cycle while no stalled result holds back a last byte; a result
// passes from the input register into the result register.
// The per-byte path is the accumulator times the base (WIDTH x 6 multiply)
// plus the digit, with overflow taken from the high bits of that sum.
// A stalled result holds the result register; further bytes are still
// taken until a second last byte reaches the input register.
// Reset clears all string state and sets the radix register to zero.
// ----------------------------------------------------------------------------
module text_to_unsigned_parser #(
	parameter int WIDTH     = tup_pkg::DEF_WIDTH,
	parameter int MAX_CHARS = tup_pkg::DEF_MAX_CHARS
) (
	input  logic              clk,
	input  logic              arst_n,
	tup_chan_if.sink          chars,
	tup_chan_if.source        result,
	tup_chan_if.sink          cfg
);
	import tup_pkg::*;

	localparam int POS_W = $clog2(MAX_CHARS);
	localparam int PROD_W = WIDTH + RADIX_W;
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_CHARS - 1);

	typedef enum logic [5:0] {
		PH_SPACE   = 6'b000001,
		PH_SIGNED  = 6'b000010,
		PH_ZERO    = 6'b000100,
		PH_AFTER_X = 6'b001000,
		PH_DIGITS  = 6'b010000,
		PH_DONE    = 6'b100000
	} phase_t;

	// input register
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;
	logic              adv;

	// string state
	phase_t             phase_q, phase_d;
	logic [WIDTH-1:0]   acc_q, acc_d;
	logic               ovf_q, ovf_d;
	logic               neg_q, neg_d;
	radix_t             base_q, base_d;
	logic [POS_W-1:0]   pos_q, pos_inc;
	logic [POS_W-1:0]   pend_q, pend_d;
	radix_t             radix_q;

	// result register
	logic               res_valid_q;
	result_item_t       res_q;
	result_item_t       res_d;

	// per-byte datapath
	radix_t             base_cur;
	radix_t             dig_base;
	radix_t             dv;
	logic               take_first;
	logic               try_digit;
	logic               digit_ok;
	logic               is_space;
	logic [PROD_W-1:0]  prod;
	logic [WIDTH-1:0]   val_w;
	logic [WIDTH+VALUE_W-1:0]  val_ext;
	logic [POS_W+OFFSET_W-1:0] off_ext;

	// handshakes
	assign adv         = valid_s1 && (!last_s1 || !res_valid_q || result.ready);
	assign chars.ready = !valid_s1 || adv;
	assign cfg.ready   = 1'b1;
	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	// radix register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= '0;
		end else if (cfg.valid) begin
			radix_q <= cfg.data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.data.character;
			last_s1 <= chars.data.last;
		end
	end

	// position and latched base
	assign base_cur = (pos_q == '0) ? radix_q : base_q;
	assign pos_inc  = (pos_q < POS_MAX) ? pos_q + 1'b1 : pos_q;
	assign dv       = char_digit(char_s1);

	// next string state for the byte in the input register
	always_comb begin
		phase_d    = phase_q;
		acc_d      = acc_q;
		ovf_d      = ovf_q;
		neg_d      = neg_q;
		base_d     = base_cur;
		pend_d     = pend_q;
		dig_base   = base_cur;
		take_first = 1'b0;
		try_digit  = 1'b0;
		is_space   = (char_s1 == CH_SPACE) || (char_s1 inside {[CH_TAB:CH_CR]});

		case (phase_q)
			PH_SPACE: begin
				if (is_space) begin
					phase_d = PH_SPACE;
				end else if (char_s1 == CH_MINUS) begin
					neg_d   = 1'b1;
					phase_d = PH_SIGNED;
				end else if (char_s1 == CH_PLUS) begin
					phase_d = PH_SIGNED;
				end else begin
					take_first = 1'b1;
				end
			end
			PH_SIGNED: begin
				take_first = 1'b1;
			end
			PH_ZERO: begin
				if (char_s1 == CH_LO_X || char_s1 == CH_UP_X) begin
					base_d  = BASE_HEX;
					phase_d = PH_AFTER_X;
				end else begin
					dig_base  = (base_cur == '0) ? BASE_OCT : base_cur;
					try_digit = 1'b1;
				end
			end
			PH_AFTER_X, PH_DIGITS: begin
				try_digit = 1'b1;
			end
			default: begin
				phase_d = phase_q;
			end
		endcase

		// first significant byte: zero prefix or first digit
		if (take_first) begin
			if ((base_cur == '0 || base_cur == BASE_HEX) && char_s1 == CH_0) begin
				pend_d  = pos_inc;
				phase_d = PH_ZERO;
			end else begin
				dig_base  = (base_cur == '0) ? BASE_DEC : base_cur;
				try_digit = 1'b1;
			end
		end

		// multiply-accumulate with overflow from the high bits
		prod     = ({{RADIX_W{1'b0}}, acc_q} * PROD_W'(dig_base)) + PROD_W'(dv);
		digit_ok = (dig_base >= BASE_MIN) && (dig_base <= BASE_MAX) && (dv < dig_base);

		if (try_digit) begin
			base_d = dig_base;
			if (digit_ok) begin
				acc_d   = prod[WIDTH-1:0];
				ovf_d   = ovf_q || (prod[PROD_W-1:WIDTH] != '0);
				pend_d  = pos_inc;
				phase_d = PH_DIGITS;
			end else begin
				phase_d = PH_DONE;
			end
		end
	end

	// result for a byte marked last
	always_comb begin
		val_w   = neg_d ? (WIDTH'(0) - acc_d) : acc_d;
		off_ext = {{OFFSET_W{1'b0}}, pend_d};
		if (pend_d == '0) begin
			val_ext = '0;
			res_d.end_offset = '0;
			res_d.status     = ST_NO_DIGITS;
		end else if (ovf_d) begin
			val_ext = {{VALUE_W{1'b0}}, {WIDTH{1'b1}}};
			res_d.end_offset = off_ext[OFFSET_W-1:0];
			res_d.status     = ST_OVERFLOW;
		end else begin
			val_ext = {{VALUE_W{1'b0}}, val_w};
			res_d.end_offset = off_ext[OFFSET_W-1:0];
			res_d.status     = ST_OK;
		end
		res_d.value = val_ext[VALUE_W-1:0];
	end

	// string state registers, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			neg_q   <= 1'b0;
			base_q  <= '0;
			pos_q   <= '0;
			pend_q  <= '0;
		end else if (adv) begin
			if (last_s1) begin
				phase_q <= PH_SPACE;
				acc_q   <= '0;
				ovf_q   <= 1'b0;
				neg_q   <= 1'b0;
				base_q  <= '0;
				pos_q   <= '0;
				pend_q  <= '0;
			end else begin
				phase_q <= phase_d;
				acc_q   <= acc_d;
				ovf_q   <= ovf_d;
				neg_q   <= neg_d;
				base_q  <= base_d;
				pos_q   <= pos_inc;
				pend_q  <= pend_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			res_q <= res_d;
		end
	end

	// a new result only follows a last byte leaving the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(adv && last_s1))
		else $error("result appeared without a last byte");

	// a stalled byte in the input register is kept
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(char_s1) && $stable(last_s1)))
		else $error("stalled input byte lost");

	// string state starts over after a last byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (pos_q == '0 && pend_q == '0 && !ovf_q))
		else $error("string state not cleared after last byte");

	// overflow can only be flagged once a digit was taken
	assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (pend_q != '0))
		else $error("overflow without parsed digits");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for text_to_unsigned_parser
// Streams strings of bytes into the parser under several radix settings and
// flow-control patterns, predicts each conversion in a scoreboard class and
// compares every result field by field.
// ----------------------------------------------------------------------------
module testbench;
	import tup_pkg::*;

	// scan state of the predicted converter
	typedef enum logic [2:0] {
		SCAN_SPACE,
		SCAN_SIGNED,
		SCAN_ZERO,
		SCAN_AFTER_X,
		SCAN_DIGITS,
		SCAN_DONE
	} scan_t;

	// predicts conversions from accepted bytes and checks the results
	class conversion_scoreboard;
		result_item_t        expected_conversions[$];
		int                  errors;
		radix_t              radix_reg;
		scan_t               scan;
		logic [VALUE_W-1:0]  acc;
		logic                ovf;
		logic                neg;
		radix_t              base;
		logic [OFFSET_W-1:0] pos;
		logic [OFFSET_W-1:0] end_pos;

		function new();
			errors = 0;
			radix_reg = '0;
			clear_string();
		endfunction

		function void clear_string();
			scan = SCAN_SPACE;
			acc = '0;
			ovf = 1'b0;
			neg = 1'b0;
			base = '0;
			pos = '0;
			end_pos = '0;
		endfunction

		task flag(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		function int pending();
			return expected_conversions.size();
		endfunction

		function void set_radix(radix_t r);
			radix_reg = r;
		endfunction

		// 0..35 for a digit character, 36 otherwise
		function int unsigned digit_of(logic [CHAR_W-1:0] c);
			if (c >= CH_0 && c <= CH_9)
				return c - CH_0;
			if (c >= CH_LO_A && c <= CH_LO_Z)
				return c - CH_LO_A + 10;
			if (c >= CH_UP_A && c <= CH_UP_Z)
				return c - CH_UP_A + 10;
			return 36;
		endfunction

		// accumulate one digit with overflow detection
		function void take_digit(logic [CHAR_W-1:0] c);
			int unsigned dv;
			logic [VALUE_W-1:0] cut;
			logic [VALUE_W-1:0] lim;
			dv = digit_of(c);
			if (base >= BASE_MIN && base <= BASE_MAX && dv < base) begin
				cut = {VALUE_W{1'b1}} / base;
				lim = {VALUE_W{1'b1}} % base;
				if (acc > cut || (acc == cut && dv > lim))
					ovf = 1'b1;
				acc = acc * base + dv;
				end_pos = pos;
				scan = SCAN_DIGITS;
			end else begin
				scan = SCAN_DONE;
			end
		endfunction

		// first byte after whitespace and sign
		function void take_first(logic [CHAR_W-1:0] c);
			if ((base == '0 || base == BASE_HEX) && c == CH_0) begin
				end_pos = pos;
				scan = SCAN_ZERO;
			end else begin
				if (base == '0)
					base = BASE_DEC;
				take_digit(c);
			end
		endfunction

		// one accepted byte
		function void accept_char(char_item_t it);
			logic [CHAR_W-1:0] c;
			result_item_t r;
			c = it.character;
			if (pos == '0)
				base = radix_reg;
			if (pos != {OFFSET_W{1'b1}})
				pos++;
			case (scan)
				SCAN_SPACE: begin
					if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
						if (c == CH_MINUS) begin
							neg = 1'b1;
							scan = SCAN_SIGNED;
						end else if (c == CH_PLUS) begin
							scan = SCAN_SIGNED;
						end else begin
							take_first(c);
						end
					end
				end
				SCAN_SIGNED: take_first(c);
				SCAN_ZERO: begin
					if (c == CH_LO_X || c == CH_UP_X) begin
						base = BASE_HEX;
						scan = SCAN_AFTER_X;
					end else begin
						if (base == '0)
							base = BASE_OCT;
						take_digit(c);
					end
				end
				SCAN_AFTER_X, SCAN_DIGITS: take_digit(c);
				default: ;
			endcase
			if (it.last) begin
				if (end_pos == '0) begin
					r.value = '0;
					r.end_offset = '0;
					r.status = ST_NO_DIGITS;
				end else if (ovf) begin
					r.value = {VALUE_W{1'b1}};
					r.end_offset = end_pos;
					r.status = ST_OVERFLOW;
				end else begin
					r.value = neg ? (32'd0 - acc) : acc;
					r.end_offset = end_pos;
					r.status = ST_OK;
				end
				expected_conversions.push_back(r);
				clear_string();
			end
		endfunction

		// compare one result with the oldest prediction
		task check_conversion(result_item_t got);
			result_item_t want;
			if (expected_conversions.size() == 0) begin
				flag($sformatf("result with none pending: value %h offset %0d status %0d",
					got.value, got.end_offset, got.status));
				return;
			end
			want = expected_conversions.pop_front();
			if (got.value !== want.value)
				flag($sformatf("value %h, predicted %h", got.value, want.value));
			if (got.end_offset !== want.end_offset)
				flag($sformatf("end_offset %0d, predicted %0d", got.end_offset, want.end_offset));
			if (got.status !== want.status)
				flag($sformatf("status %0d, predicted %0d", got.status, want.status));
		endtask
	endclass

	logic clk;
	logic arst_n;

	tup_chan_if #(.payload_t(char_item_t))   chars ();
	tup_chan_if #(.payload_t(result_item_t)) result ();
	tup_chan_if #(.payload_t(radix_t))       cfg ();

	text_to_unsigned_parser DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.result (result),
		.cfg    (cfg)
	);

	conversion_scoreboard sb = new();

	int          idle_pct;
	int          stall_pct;
	int unsigned hold_cycles = 0;
	logic        hold_req = 1'b0;
	logic        hold_done = 1'b0;
	int          chars_sent;
	radix_t      radix_now;
	logic [CHAR_W-1:0] text_buf[$];

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// receiver: random stalls, one long hold-off on request
	always @(posedge clk) begin
		if (hold_cycles != 0) begin
			result.ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else if (hold_req && !hold_done) begin
			result.ready <= 1'b0;
			hold_cycles <= 299;
			hold_done <= 1'b1;
		end else begin
			result.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// byte transfers feed the predictor
	always @(posedge clk) begin
		if (arst_n && chars.valid && chars.ready)
			sb.accept_char(chars.data);
	end

	// result transfers are checked
	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready)
			sb.check_conversion(result.data);
	end

	// register writes update the predicted radix
	always @(posedge clk) begin
		if (arst_n && cfg.valid && cfg.ready)
			sb.set_radix(cfg.data);
	end

	// offer one byte, with random idle cycles ahead of it
	task automatic send_char(input logic [CHAR_W-1:0] c, input logic l);
		char_item_t it;
		it.character = c;
		it.last = l;
		while ($urandom_range(99) < idle_pct) begin
			chars.valid <= 1'b0;
			chars.data <= {CHAR_W'($urandom), 1'b0};
			@(posedge clk);
		end
		chars.valid <= 1'b1;
		chars.data <= it;
		do @(posedge clk); while (!chars.ready);
		chars_sent++;
	endtask

	// send the buffered string, last on its final byte
	task automatic send_text();
		foreach (text_buf[i])
			send_char(text_buf[i], i == text_buf.size() - 1);
		text_buf.delete();
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
		send_text();
	endtask

	// stop offering until every predicted result has arrived
	task automatic drain();
		chars.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// radix write while the parser is idle
	task automatic write_radix(input radix_t r);
		drain();
		repeat (4) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= r;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		radix_now = r;
		@(posedge clk);
	endtask

	function automatic logic [CHAR_W-1:0] rand_digit(input int b);
		int v;
		v = $urandom_range(b - 1);
		if (v < 10)
			return CHAR_W'(CH_0 + v);
		return CHAR_W'(($urandom_range(1) ? CH_LO_A : CH_UP_A) + v - 10);
	endfunction

	function automatic logic [CHAR_W-1:0] rand_space();
		int k;
		k = $urandom_range(5);
		return (k == 5) ? CH_SPACE : CHAR_W'(CH_TAB + k);
	endfunction

	// mostly well-formed numbers with random content, some noise
	task automatic build_string();
		int kind;
		int n;
		int b;
		kind = $urandom_range(99);
		if (kind < 15) begin
			n = $urandom_range(1, 8);
			repeat (n) text_buf.push_back(CHAR_W'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(0, 3)) text_buf.push_back(rand_space());
			case ($urandom_range(3))
				0: text_buf.push_back(CH_MINUS);
				1: text_buf.push_back(CH_PLUS);
				default: ;
			endcase
			b = radix_now;
			if (radix_now == 0 || radix_now == BASE_HEX) begin
				case ($urandom_range(2))
					0: if (radix_now == 0) b = 10;
					1: begin
						text_buf.push_back(CH_0);
						if (radix_now == 0) b = 8;
					end
					default: begin
						text_buf.push_back(CH_0);
						text_buf.push_back($urandom_range(1) ? CH_LO_X : CH_UP_X);
						b = 16;
					end
				endcase
			end
			if (b < 2 || b > 36)
				b = 36;
			// long digit runs push into overflow
			n = (kind < 30) ? $urandom_range(8, 40) : $urandom_range(0, 10);
			repeat (n) text_buf.push_back(rand_digit(b));
			if ($urandom_range(1))
				repeat ($urandom_range(1, 3))
					text_buf.push_back(CHAR_W'($urandom_range(255)));
		end
		if (text_buf.size() == 0)
			text_buf.push_back(CHAR_W'($urandom_range(255)));
	endtask

	// stimulus
	initial begin
		int unsigned settings[12];
		int target;
		arst_n = 1'b0;
		chars.valid <= 1'b0;
		chars.data <= '0;
		cfg.valid <= 1'b0;
		cfg.data <= '0;
		idle_pct = 0;
		stall_pct = 0;
		chars_sent = 0;
		radix_now = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: prefix detection from the reset radix, then radix 16, 36 and 63
		send_str(" -0x1fZ");
		send_str("0x");
		send_str("+");
		send_str("\t");
		send_str("077");
		write_radix(BASE_HEX);
		send_str("0XfF");
		write_radix(BASE_MAX);
		send_str("zzzzzzz");
		write_radix(radix_t'(63));
		send_str("5");

		// random part: four flow-control phases, three radix settings each
		settings = '{0, 10, 16, 2, 36, 8, 0, 37, 1, 63, 0, 0};
		settings[10] = $urandom_range(63);
		settings[11] = $urandom_range(63);
		for (int s = 0; s < 12; s++) begin
			write_radix(radix_t'(settings[s]));
			case (s / 3)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 45; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 45; end
				default: begin idle_pct = 31; stall_pct = 31; end
			endcase
			// receiver holds off while bytes keep coming
			if (s == 0)
				hold_req <= 1'b1;
			target = chars_sent + 108;
			while (chars_sent < target) begin
				build_string();
				send_text();
				if (s == 7 && chars_sent > target - 54 && chars_sent < target - 40)
					drain();
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (sb.pending() != 0)
			sb.flag($sformatf("%0d predicted results never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: sim.f
sv/tup_pkg.sv
sv/tup_chan_if.sv
sv/text_to_unsigned_parser.sv
tb/testbench.sv
